// ===== hw/rtl/nsrf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nsrf_pkg
// Types, widths and the arithmetic step program shared by the nearest-sphere
// controller and datapath.
// ----------------------------------------------------------------------------
package nsrf_pkg;

    localparam int CRD_W   = 24;   // Q12.12 coordinate
    localparam int DIR_W   = 16;
    localparam int RAD_W   = 23;
    localparam int IDX_W   = 16;
    localparam int CFG_W   = 24;
    localparam int REL_W   = 25;   // centre - origin
    localparam int OPND_W  = 33;   // shared multiplier operand, signed
    localparam int PROD_W  = 2 * OPND_W;
    localparam int ACC_W   = 85;
    localparam int DOT_W   = 42;
    localparam int CRS_W   = 42;   // one cross product component, signed
    localparam int CRS_LO  = 21;   // low split of a component
    localparam int DD_W    = 32;
    localparam int R2_W    = 46;
    localparam int R2_LO   = 23;
    localparam int LIM_W   = 78;
    localparam int SUMSQ_W = 82;
    localparam int DIST_W  = 50;

    localparam int MAX_CENTRES = 65536;
    localparam logic [IDX_W:0] MAX_POS = (IDX_W + 1)'(MAX_CENTRES);

    localparam int NUM_UOPS = 27;
    localparam int STEP_W   = $clog2(NUM_UOPS);

    typedef enum logic [2:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_ORIGIN_Z    = 3'd2,
        CFG_DIR_X       = 3'd3,
        CFG_DIR_Y       = 3'd4,
        CFG_DIR_Z       = 3'd5,
        CFG_RADIUS      = 3'd6,
        CFG_START_INDEX = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OPND_RX, OPND_RY, OPND_RZ,
        OPND_DX, OPND_DY, OPND_DZ,
        OPND_RAD, OPND_R2_LO, OPND_R2_HI, OPND_DD,
        OPND_CX_LO, OPND_CX_HI, OPND_CY_LO, OPND_CY_HI, OPND_CZ_LO, OPND_CZ_HI
    } t_opnd;

    localparam int NUM_OPND = 16;

    typedef enum logic [1:0] {SH_0, SH_22, SH_23, SH_42} t_shift;
    typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} t_acc;
    typedef enum logic [3:0] {
        DST_NONE, DST_DD, DST_R2, DST_CX, DST_CY, DST_CZ,
        DST_DOT, DST_LIM, DST_DIST, DST_SUMSQ
    } t_dest;

    typedef struct packed {
        t_opnd  a;
        t_opnd  b;
        t_shift sh;
        t_acc   acc;
        t_dest  dst;
    } t_uop;

    typedef struct packed {
        logic              load;
        logic              issue;
        logic [STEP_W-1:0] step;
        logic              decide;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_valid;
    } t_sts;

    // Multiply-accumulate program for one centre
    function automatic t_uop uop_at(input logic [STEP_W-1:0] step);
        t_uop u;
        unique case (step)
            5'd0:    u = '{OPND_DX,    OPND_DX,    SH_0,  ACC_LOAD, DST_NONE};
            5'd1:    u = '{OPND_DY,    OPND_DY,    SH_0,  ACC_ADD,  DST_NONE};
            5'd2:    u = '{OPND_DZ,    OPND_DZ,    SH_0,  ACC_ADD,  DST_DD};
            5'd3:    u = '{OPND_RAD,   OPND_RAD,   SH_0,  ACC_LOAD, DST_R2};
            5'd4:    u = '{OPND_RY,    OPND_DZ,    SH_0,  ACC_LOAD, DST_NONE};
            5'd5:    u = '{OPND_RZ,    OPND_DY,    SH_0,  ACC_SUB,  DST_CX};
            5'd6:    u = '{OPND_RZ,    OPND_DX,    SH_0,  ACC_LOAD, DST_NONE};
            5'd7:    u = '{OPND_RX,    OPND_DZ,    SH_0,  ACC_SUB,  DST_CY};
            5'd8:    u = '{OPND_RX,    OPND_DY,    SH_0,  ACC_LOAD, DST_NONE};
            5'd9:    u = '{OPND_RY,    OPND_DX,    SH_0,  ACC_SUB,  DST_CZ};
            5'd10:   u = '{OPND_RX,    OPND_DX,    SH_0,  ACC_LOAD, DST_NONE};
            5'd11:   u = '{OPND_RY,    OPND_DY,    SH_0,  ACC_ADD,  DST_NONE};
            5'd12:   u = '{OPND_RZ,    OPND_DZ,    SH_0,  ACC_ADD,  DST_DOT};
            5'd13:   u = '{OPND_R2_LO, OPND_DD,    SH_0,  ACC_LOAD, DST_NONE};
            5'd14:   u = '{OPND_R2_HI, OPND_DD,    SH_23, ACC_ADD,  DST_LIM};
            5'd15:   u = '{OPND_RX,    OPND_RX,    SH_0,  ACC_LOAD, DST_NONE};
            5'd16:   u = '{OPND_RY,    OPND_RY,    SH_0,  ACC_ADD,  DST_NONE};
            5'd17:   u = '{OPND_RZ,    OPND_RZ,    SH_0,  ACC_ADD,  DST_DIST};
            5'd18:   u = '{OPND_CX_LO, OPND_CX_LO, SH_0,  ACC_LOAD, DST_NONE};
            5'd19:   u = '{OPND_CX_HI, OPND_CX_LO, SH_22, ACC_ADD,  DST_NONE};
            5'd20:   u = '{OPND_CX_HI, OPND_CX_HI, SH_42, ACC_ADD,  DST_NONE};
            5'd21:   u = '{OPND_CY_LO, OPND_CY_LO, SH_0,  ACC_ADD,  DST_NONE};
            5'd22:   u = '{OPND_CY_HI, OPND_CY_LO, SH_22, ACC_ADD,  DST_NONE};
            5'd23:   u = '{OPND_CY_HI, OPND_CY_HI, SH_42, ACC_ADD,  DST_NONE};
            5'd24:   u = '{OPND_CZ_LO, OPND_CZ_LO, SH_0,  ACC_ADD,  DST_NONE};
            5'd25:   u = '{OPND_CZ_HI, OPND_CZ_LO, SH_22, ACC_ADD,  DST_NONE};
            5'd26:   u = '{OPND_CZ_HI, OPND_CZ_HI, SH_42, ACC_ADD,  DST_SUMSQ};
            default: u = '{OPND_RX,    OPND_RX,    SH_0,  ACC_LOAD, DST_NONE};
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/nsrf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nsrf_ctrl
// Sequencer: takes a centre, steps the datapath through the multiply program,
// then issues the hit decision, holding a last centre's decision until the result register is free.
// ----------------------------------------------------------------------------
module nsrf_ctrl
    import nsrf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_DRAIN, S_DECIDE} t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic              w_out_free;

    assign w_out_free = !i_sts.last || !i_sts.out_valid || i_out_ready;

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.issue   = (r_state == S_CALC);
    assign o_cmd.step    = r_step;
    assign o_cmd.decide  = (r_state == S_DECIDE) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (i_in_valid) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(NUM_UOPS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/nsrf_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nsrf_dpath
// Configuration registers, one shared 33x33 multiplier with an accumulator,
// the running nearest-hit search and the result register.
// ----------------------------------------------------------------------------
module nsrf_dpath
    import nsrf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic [CRD_W-1:0] i_cx,
    input  wire logic [CRD_W-1:0] i_cy,
    input  wire logic [CRD_W-1:0] i_cz,
    input  wire logic             i_last,
    input  wire t_cmd             i_cmd,
    output t_sts                  o_sts,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_found,
    output logic [IDX_W-1:0]      o_index
);

    // configuration
    logic signed [CRD_W-1:0] r_ox, r_oy, r_oz;
    logic signed [DIR_W-1:0] r_dx, r_dy, r_dz;
    logic [RAD_W-1:0]        r_rad;
    logic [IDX_W-1:0]        r_start;

    // current centre
    logic signed [REL_W-1:0] r_rx, r_ry, r_rz;
    logic                    r_last;
    logic [IDX_W-1:0]        r_pos;

    // search state
    logic [IDX_W-1:0]  r_counter;
    logic              r_active;
    logic              r_have;
    logic [IDX_W-1:0]  r_best_pos;
    logic [DIST_W-1:0] r_best_dist;

    // multiply-accumulate
    logic signed [OPND_W-1:0] w_src [NUM_OPND];
    logic signed [OPND_W-1:0] w_opa, w_opb;
    t_uop                     w_uop;
    logic signed [PROD_W-1:0] r_prod;
    t_uop                     r_uop_d;
    logic                     r_issue_d;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_ext, w_term, w_acc_new;

    // stored terms
    logic [DD_W-1:0]         r_dd;
    logic [R2_W-1:0]         r_r2;
    logic signed [CRS_W-1:0] r_crx, r_cry, r_crz;
    logic signed [DOT_W-1:0] r_dot;
    logic [LIM_W-1:0]        r_lim;
    logic [DIST_W-1:0]       r_dist;
    logic [SUMSQ_W-1:0]      r_sumsq;

    // output register
    logic             r_out_valid;
    logic             r_found;
    logic [IDX_W-1:0] r_index;

    logic w_hit, w_take, n_have;
    logic [IDX_W-1:0] n_best_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox    <= '0;
            r_oy    <= '0;
            r_oz    <= '0;
            r_dx    <= '0;
            r_dy    <= '0;
            r_dz    <= '0;
            r_rad   <= '0;
            r_start <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X:    r_ox    <= i_cfg_data;
                CFG_ORIGIN_Y:    r_oy    <= i_cfg_data;
                CFG_ORIGIN_Z:    r_oz    <= i_cfg_data;
                CFG_DIR_X:       r_dx    <= i_cfg_data[DIR_W-1:0];
                CFG_DIR_Y:       r_dy    <= i_cfg_data[DIR_W-1:0];
                CFG_DIR_Z:       r_dz    <= i_cfg_data[DIR_W-1:0];
                CFG_RADIUS:      r_rad   <= i_cfg_data[RAD_W-1:0];
                CFG_START_INDEX: r_start <= i_cfg_data[IDX_W-1:0];
                default:         r_start <= r_start;
            endcase
        end
    end

    // centre capture and index assignment
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rx   <= {i_cx[CRD_W-1], i_cx} - {r_ox[CRD_W-1], r_ox};
            r_ry   <= {i_cy[CRD_W-1], i_cy} - {r_oy[CRD_W-1], r_oy};
            r_rz   <= {i_cz[CRD_W-1], i_cz} - {r_oz[CRD_W-1], r_oz};
            r_last <= i_last;
            r_pos  <= r_active ? r_counter : r_start;
        end
    end

    // operand sources
    always_comb begin
        w_src[OPND_RX]    = OPND_W'(r_rx);
        w_src[OPND_RY]    = OPND_W'(r_ry);
        w_src[OPND_RZ]    = OPND_W'(r_rz);
        w_src[OPND_DX]    = OPND_W'(r_dx);
        w_src[OPND_DY]    = OPND_W'(r_dy);
        w_src[OPND_DZ]    = OPND_W'(r_dz);
        w_src[OPND_RAD]   = {{(OPND_W - RAD_W){1'b0}}, r_rad};
        w_src[OPND_R2_LO] = {{(OPND_W - R2_LO){1'b0}}, r_r2[R2_LO-1:0]};
        w_src[OPND_R2_HI] = {{(OPND_W - R2_W + R2_LO){1'b0}}, r_r2[R2_W-1:R2_LO]};
        w_src[OPND_DD]    = {{(OPND_W - DD_W){1'b0}}, r_dd};
        w_src[OPND_CX_LO] = {{(OPND_W - CRS_LO){1'b0}}, r_crx[CRS_LO-1:0]};
        w_src[OPND_CX_HI] = OPND_W'(signed'(r_crx[CRS_W-1:CRS_LO]));
        w_src[OPND_CY_LO] = {{(OPND_W - CRS_LO){1'b0}}, r_cry[CRS_LO-1:0]};
        w_src[OPND_CY_HI] = OPND_W'(signed'(r_cry[CRS_W-1:CRS_LO]));
        w_src[OPND_CZ_LO] = {{(OPND_W - CRS_LO){1'b0}}, r_crz[CRS_LO-1:0]};
        w_src[OPND_CZ_HI] = OPND_W'(signed'(r_crz[CRS_W-1:CRS_LO]));
    end

    assign w_uop = uop_at(i_cmd.step);
    assign w_opa = w_src[w_uop.a];
    assign w_opb = w_src[w_uop.b];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_d <= 1'b0;
        end else begin
            r_issue_d <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_prod  <= w_opa * w_opb;
            r_uop_d <= w_uop;
        end
    end

    assign w_ext = ACC_W'(r_prod);

    always_comb begin
        case (r_uop_d.sh)
            SH_22:   w_term = w_ext <<< 22;
            SH_23:   w_term = w_ext <<< R2_LO;
            SH_42:   w_term = w_ext <<< (2 * CRS_LO);
            default: w_term = w_ext;
        endcase
        case (r_uop_d.acc)
            ACC_ADD: w_acc_new = r_acc + w_term;
            ACC_SUB: w_acc_new = r_acc - w_term;
            default: w_acc_new = w_term;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_issue_d) begin
            r_acc <= w_acc_new;
            case (r_uop_d.dst)
                DST_DD:    r_dd    <= w_acc_new[DD_W-1:0];
                DST_R2:    r_r2    <= w_acc_new[R2_W-1:0];
                DST_CX:    r_crx   <= w_acc_new[CRS_W-1:0];
                DST_CY:    r_cry   <= w_acc_new[CRS_W-1:0];
                DST_CZ:    r_crz   <= w_acc_new[CRS_W-1:0];
                DST_DOT:   r_dot   <= w_acc_new[DOT_W-1:0];
                DST_LIM:   r_lim   <= w_acc_new[LIM_W-1:0];
                DST_DIST:  r_dist  <= w_acc_new[DIST_W-1:0];
                DST_SUMSQ: r_sumsq <= w_acc_new[SUMSQ_W-1:0];
                default:   r_dd    <= r_dd;
            endcase
        end
    end

    // hit test and nearest update
    assign w_hit = (r_dot > DOT_W'(0)) && ({1'b0, r_pos} < MAX_POS)
                   && (r_sumsq < {{(SUMSQ_W - LIM_W){1'b0}}, r_lim});
    assign w_take     = w_hit && (!r_have || (r_dist < r_best_dist));
    assign n_have     = r_have || w_take;
    assign n_best_pos = w_take ? r_pos : r_best_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter   <= '0;
            r_active    <= 1'b0;
            r_have      <= 1'b0;
            r_best_pos  <= '0;
            r_best_dist <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_counter <= (r_active ? r_counter : r_start) + 1'b1;
                r_active  <= 1'b1;
            end
            if (i_cmd.decide) begin
                if (r_last) begin
                    r_active    <= 1'b0;
                    r_have      <= 1'b0;
                    r_best_pos  <= '0;
                    r_best_dist <= '0;
                end else if (w_take) begin
                    r_have      <= 1'b1;
                    r_best_pos  <= r_pos;
                    r_best_dist <= r_dist;
                end
            end
            if (i_cmd.decide && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && r_last) begin
            r_found <= n_have;
            r_index <= n_have ? n_best_pos : '0;
        end
    end

    assign o_sts.last      = r_last;
    assign o_sts.out_valid = r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_index         = r_index;

endmodule
`default_nettype wire

// ===== hw/rtl/nearest_sphere_on_ray_finder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_sphere_on_ray_finder
// Finds the nearest sphere centre lying ahead of a configured ray.
// ----------------------------------------------------------------------------
// Usage:
//   Write origin, direction, radius and start index through i_cfg_* while
//   idle. Centres then arrive on the s_axis channel, one beat each; the beat
//   with s_axis_tlast ends a search and makes one m_axis beat carrying the
//   found flag (tuser) and the nearest index (tdata, 0 if none).
//   For each centre the steps are: form centre - origin, make 27 passes
//   through the single shared 33x33 multiply-accumulate unit, drain its
//   pipeline and take the hit decision. s_axis_tready is high only
//   between centres. The result beat sits in an output register; the next
//   search may start while it waits. A stalled receiver holds up only a
//   later last beat, which waits in its decision cycle until the register
//   frees. Reset clears the configuration to zero, drops any search in
//   progress and empties the output register.
// ----------------------------------------------------------------------------
module nearest_sphere_on_ray_finder
    import nsrf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [3*CRD_W-1:0] s_axis_tdata,  // centre_x, centre_y, centre_z
    input  wire logic             s_axis_tlast,    // last_centre
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [IDX_W-1:0]      m_axis_tdata,    // nearest_index
    output logic                  m_axis_tuser     // found
);

    t_cmd w_cmd;
    t_sts w_sts;

    nsrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    nsrf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cx        (s_axis_tdata[CRD_W-1:0]),
        .i_cy        (s_axis_tdata[2*CRD_W-1:CRD_W]),
        .i_cz        (s_axis_tdata[3*CRD_W-1:2*CRD_W]),
        .i_last      (s_axis_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_found     (m_axis_tuser),
        .o_index     (m_axis_tdata)
    );

    // a pending result beat is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.decide && w_sts.last |-> !m_axis_tvalid || m_axis_tready)
        else $error("result overwritten");

    // busy after taking a centre
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("centre accepted while busy");

    // a result beat only follows a decision
    a_out_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.decide))
        else $error("result without decision");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("nonzero index without hit");

endmodule
`default_nettype wire
